[src/pidic_pkg.sv]
// ----------------------------------------------------------------------------
// pidic_pkg: shared types and constants for the PID controller core
// Holds register indexes, mode codes, fixed-point limits and the helper that
// saturates a wide signed sum to a 32-bit word.
// ----------------------------------------------------------------------------
package pidic_pkg;

  // Word and wide-sum widths
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned TOTAL_W = 70;

  typedef logic signed [WORD_W-1:0] q_t;

  // Saturated word plus a clip flag
  typedef struct packed {
    q_t   value;
    logic clip;
  } sat_t;

  // Item modes
  localparam logic [1:0] MODE_STEP    = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_RESTORE = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INT_TIME   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DER_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FORM       = 3'd5;

  // Integer part of the integral clamp after reset
  localparam int unsigned LIMIT_RESET_INT = 12000;

  // Signed 32-bit range
  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  // Clip a wide signed value to the 32-bit range
  function automatic sat_t sat_q(input logic signed [TOTAL_W-1:0] v);
    sat_t r;
    r.clip = 1'b1;
    if (v > TOTAL_W'(Q_MAX)) begin
      r.value = Q_MAX;
    end else if (v < TOTAL_W'(Q_MIN)) begin
      r.value = Q_MIN;
    end else begin
      r.value = v[WORD_W-1:0];
      r.clip  = 1'b0;
    end
    return r;
  endfunction

endpackage

[src/pid_controller_integral_clamp_core.sv]
// ----------------------------------------------------------------------------
// pid_controller_integral_clamp_core: PID step with clamped integral
// Derivative on measurement, ideal or parallel form, one shared multiplier
// and one shared radix-4 divider under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_*: s_tuser carries the mode (step, load integral,
//   restore integral), s_tdata the time step, measurement, setpoint and the
//   integral load value. Each input beat yields exactly one output beat on
//   m_*: drive and integral in m_tdata, the drive clip flag in m_tuser.
//   Registers are written through cfg_we / cfg_index / cfg_wdata while idle.
// Sequencing:
//   s_tready is high only while the sequencer is idle, so a new item is
//   taken only after the last result has been handed to the output
//   register. Each division by dt or Ti holds the shared divider (two
//   quotient bits a cycle), each multiply holds the 32x32 multiplier;
//   zero dt skips the dt division, zero Ti the integral-term unit.
//   Load, restore and unused-mode items go straight from idle to the
//   output step.
// Reset and stall:
//   rst (synchronous) clears the integral, its previous value, the last
//   measurement and restores the register defaults. The output register
//   holds its beat while m_tready is low; the next item can be taken then,
//   and its result waits in the last step until the register frees up.
// ----------------------------------------------------------------------------
module pid_controller_integral_clamp_core
  import pidic_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  // Input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [127:0]         s_tdata,  // time_step, measurement, target, integral_load
  input  logic [1:0]           s_tuser,  // mode
  // Output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,  // drive, integral_now
  output logic                 m_tuser   // drive_saturated
);

  // Reset values that follow from the fraction width
  localparam logic [63:0] LIMIT_FULL = 64'(LIMIT_RESET_INT) << FRAC_BITS;
  localparam logic [30:0] LIMIT_INIT =
    (LIMIT_FULL > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : LIMIT_FULL[30:0];
  localparam logic [63:0] ONE_FULL   = 64'd1 << FRAC_BITS;
  localparam q_t          GAIN_INIT  = ONE_FULL[WORD_W-1:0];

  // Sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_PREP     = 4'd1;
  localparam logic [3:0] ST_MUL      = 4'd2;
  localparam logic [3:0] ST_DIV      = 4'd3;
  localparam logic [3:0] ST_D_START  = 4'd4;
  localparam logic [3:0] ST_D_TAKE   = 4'd5;
  localparam logic [3:0] ST_I_ADD    = 4'd6;
  localparam logic [3:0] ST_I_CLAMP  = 4'd7;
  localparam logic [3:0] ST_IT_START = 4'd8;
  localparam logic [3:0] ST_IT_TAKE  = 4'd9;
  localparam logic [3:0] ST_G_START  = 4'd10;
  localparam logic [3:0] ST_G_TAKE   = 4'd11;
  localparam logic [3:0] ST_FIN      = 4'd12;

  // Input fields
  logic [1:0]  mode;
  logic [31:0] time_step;
  q_t          measurement;
  q_t          target;
  q_t          integral_load;

  assign mode          = s_tuser;
  assign time_step     = s_tdata[31:0];
  assign measurement   = s_tdata[63:32];
  assign target        = s_tdata[95:64];
  assign integral_load = s_tdata[127:96];

  // Configuration registers
  q_t          bias;
  q_t          gain;
  q_t          integral_time;
  q_t          derivative_time;
  logic [30:0] integral_limit;
  logic        form_select;

  // Controller state
  q_t integral_acc;
  q_t integral_prev;
  q_t last_measurement;

  // Sequencer
  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] ret;
  logic [3:0] ret_next;

  // Item working registers
  logic [31:0]               dt;
  q_t                        meas;
  logic signed [32:0]        err;
  logic signed [32:0]        dmeas;
  q_t                        dterm;
  q_t                        iterm;
  logic signed [TOTAL_W-1:0] acc_sum;
  logic signed [TOTAL_W-1:0] total;

  // Shared multiplier
  logic              mul_go;
  logic [35:0]       mul_a_in;
  logic [31:0]       mul_b_in;
  logic              mul_neg_in;
  logic [35:0]       mul_a;
  logic [31:0]       mul_b;
  logic              mul_neg;
  logic [1:0]        mul_cnt;
  logic [31:0]       mul_x;
  logic [63:0]       mul_res;
  logic [63:0]       mul_p;
  logic [67:0]       prod;
  logic [67:0]       prod_sh;
  logic signed [68:0] mul_q;

  // Shared divider
  logic        div_go;
  logic [63:0] div_num_in;
  logic [31:0] div_den_in;
  logic        div_neg_in;
  logic [31:0] div_rem;
  logic [31:0] div_lo;
  logic [31:0] div_den;
  logic [31:0] div_quo;
  logic        div_neg;
  logic        div_ovf;
  logic [3:0]  div_cnt;
  logic [32:0] r1;
  logic [32:0] r1s;
  logic [32:0] r2;
  logic [32:0] r2s;
  logic        ge1;
  logic        ge2;
  q_t          div_val;

  // Magnitudes and helpers
  logic [32:0]        err_neg;
  logic [31:0]        err_mag;
  logic [32:0]        dmeas_neg;
  logic [31:0]        dmeas_mag;
  logic [31:0]        td_mag;
  logic [31:0]        ti_mag;
  logic [31:0]        gain_mag;
  logic [31:0]        acc_mag;
  logic signed [34:0] sum_pid;
  logic [34:0]        sum_neg;
  logic [34:0]        sum_mag;
  logic signed [TOTAL_W-1:0] lim_pos;
  logic signed [TOTAL_W-1:0] lim_neg;
  q_t                 acc_clamped;
  sat_t               iterm_mul;
  sat_t               drive_sat;
  logic               out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Operand magnitudes
  assign err_neg   = -err;
  assign err_mag   = err[32] ? err_neg[31:0] : err[31:0];
  assign dmeas_neg = -dmeas;
  assign dmeas_mag = dmeas[32] ? dmeas_neg[31:0] : dmeas[31:0];
  assign td_mag    = derivative_time[31] ? 32'(-derivative_time) : derivative_time;
  assign ti_mag    = integral_time[31] ? 32'(-integral_time) : integral_time;
  assign gain_mag  = gain[31] ? 32'(-gain) : gain;
  assign acc_mag   = integral_acc[31] ? 32'(-integral_acc) : integral_acc;
  assign sum_pid   = 35'(err) + 35'(iterm) - 35'(dterm);
  assign sum_neg   = -sum_pid;
  assign sum_mag   = sum_pid[34] ? sum_neg : sum_pid;

  // Signed, truncated-toward-zero view of the product over 2^FRAC_BITS
  assign prod_sh = prod >> FRAC_BITS;
  assign mul_q   = mul_neg ? -$signed({1'b0, prod_sh}) : $signed({1'b0, prod_sh});
  assign mul_x   = (mul_cnt == 2'd0) ? mul_a[31:0] : {28'b0, mul_a[35:32]};
  assign mul_res = mul_x * mul_b;

  // Integral clamp window
  assign lim_pos = $signed({39'b0, integral_limit});
  assign lim_neg = -lim_pos;
  always_comb begin
    if (acc_sum > lim_pos) begin
      acc_clamped = lim_pos[WORD_W-1:0];
    end else if (acc_sum < lim_neg) begin
      acc_clamped = lim_neg[WORD_W-1:0];
    end else begin
      acc_clamped = acc_sum[WORD_W-1:0];
    end
  end

  assign iterm_mul = sat_q(TOTAL_W'(mul_q));
  assign drive_sat = sat_q(total);

  // Two restoring quotient steps per cycle
  assign r1  = {div_rem, div_lo[31]};
  assign ge1 = (r1 >= {1'b0, div_den});
  assign r1s = ge1 ? (r1 - {1'b0, div_den}) : r1;
  assign r2  = {r1s[31:0], div_lo[30]};
  assign ge2 = (r2 >= {1'b0, div_den});
  assign r2s = ge2 ? (r2 - {1'b0, div_den}) : r2;

  // Signed, saturated quotient
  always_comb begin
    if (div_ovf) begin
      div_val = div_neg ? Q_MIN : Q_MAX;
    end else if (div_neg) begin
      div_val = (div_quo > 32'h8000_0000) ? Q_MIN : 32'(-div_quo);
    end else begin
      div_val = div_quo[31] ? Q_MAX : div_quo;
    end
  end

  // Sequencer and unit requests
  always_comb begin
    state_next = state;
    ret_next   = ret;
    mul_go     = 1'b0;
    mul_a_in   = '0;
    mul_b_in   = '0;
    mul_neg_in = 1'b0;
    div_go     = 1'b0;
    div_num_in = '0;
    div_den_in = '0;
    div_neg_in = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (mode == MODE_STEP) ? ST_PREP : ST_FIN;
        end
      end
      ST_PREP: begin
        mul_go     = 1'b1;
        mul_a_in   = {4'b0, dmeas_mag};
        mul_b_in   = td_mag;
        mul_neg_in = dmeas[32] ^ derivative_time[31];
        ret_next   = ST_D_START;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_cnt == 2'd2) begin
          state_next = ret;
        end
      end
      ST_DIV: begin
        if (div_cnt == 4'd15) begin
          state_next = ret;
        end
      end
      ST_D_START: begin
        if (dt == 32'd0) begin
          state_next = ST_D_TAKE;
        end else begin
          div_go     = 1'b1;
          div_num_in = prod[63:0];
          div_den_in = dt;
          div_neg_in = mul_neg;
          ret_next   = ST_D_TAKE;
          state_next = ST_DIV;
        end
      end
      ST_D_TAKE: begin
        mul_go     = 1'b1;
        mul_a_in   = {4'b0, err_mag};
        mul_b_in   = dt;
        mul_neg_in = err[32];
        ret_next   = ST_I_ADD;
        state_next = ST_MUL;
      end
      ST_I_ADD: begin
        state_next = ST_I_CLAMP;
      end
      ST_I_CLAMP: begin
        state_next = ST_IT_START;
      end
      ST_IT_START: begin
        if (integral_time == '0) begin
          state_next = ST_IT_TAKE;
        end else if (!form_select) begin
          div_go     = 1'b1;
          div_num_in = {32'b0, acc_mag} << FRAC_BITS;
          div_den_in = ti_mag;
          div_neg_in = integral_acc[31] ^ integral_time[31];
          ret_next   = ST_IT_TAKE;
          state_next = ST_DIV;
        end else begin
          mul_go     = 1'b1;
          mul_a_in   = {4'b0, acc_mag};
          mul_b_in   = ti_mag;
          mul_neg_in = integral_acc[31] ^ integral_time[31];
          ret_next   = ST_IT_TAKE;
          state_next = ST_MUL;
        end
      end
      ST_IT_TAKE: begin
        state_next = ST_G_START;
      end
      ST_G_START: begin
        mul_go   = 1'b1;
        mul_b_in = gain_mag;
        if (!form_select) begin
          mul_a_in   = {1'b0, sum_mag};
          mul_neg_in = sum_pid[34] ^ gain[31];
        end else begin
          mul_a_in   = {4'b0, err_mag};
          mul_neg_in = err[32] ^ gain[31];
        end
        ret_next   = ST_G_TAKE;
        state_next = ST_MUL;
      end
      ST_G_TAKE: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bias            <= '0;
      gain            <= GAIN_INIT;
      integral_time   <= '0;
      derivative_time <= '0;
      integral_limit  <= LIMIT_INIT;
      form_select     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIAS:      bias            <= cfg_wdata;
        REG_GAIN:      gain            <= cfg_wdata;
        REG_INT_TIME:  integral_time   <= cfg_wdata;
        REG_DER_TIME:  derivative_time <= cfg_wdata;
        REG_INT_LIMIT: integral_limit  <= cfg_wdata[30:0];
        REG_FORM:      form_select     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // Multiplier: low half, then high half, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_cnt <= '0;
    end else if (mul_go) begin
      mul_cnt <= '0;
    end else if (state == ST_MUL) begin
      mul_cnt <= mul_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_go) begin
      mul_a   <= mul_a_in;
      mul_b   <= mul_b_in;
      mul_neg <= mul_neg_in;
    end else if (state == ST_MUL) begin
      case (mul_cnt)
        2'd0: begin
          mul_p <= mul_res;
        end
        2'd1: begin
          prod  <= {4'b0, mul_p};
          mul_p <= mul_res;
        end
        default: begin
          prod <= prod + {mul_p[35:0], 32'b0};
        end
      endcase
    end
  end

  // Divider: overflow check up front, then sixteen radix-4 steps
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_go) begin
      div_cnt <= '0;
    end else if (state == ST_DIV) begin
      div_cnt <= div_cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_go) begin
      div_rem <= div_num_in[63:32];
      div_lo  <= div_num_in[31:0];
      div_den <= div_den_in;
      div_neg <= div_neg_in;
      div_ovf <= (div_num_in[63:32] >= div_den_in);
    end else if (state == ST_DIV) begin
      div_rem <= r2s[31:0];
      div_lo  <= {div_lo[29:0], 2'b00};
      div_quo <= {div_quo[29:0], ge1, ge2};
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        dt    <= time_step;
        meas  <= measurement;
        err   <= 33'(target) - 33'(measurement);
        dmeas <= 33'(measurement) - 33'(last_measurement);
        total <= '0;
      end
      ST_D_TAKE: begin
        dterm <= (dt == 32'd0) ? '0 : div_val;
      end
      ST_I_ADD: begin
        acc_sum <= TOTAL_W'(integral_acc) + TOTAL_W'(mul_q);
      end
      ST_IT_TAKE: begin
        if (integral_time == '0) begin
          iterm <= '0;
        end else begin
          iterm <= form_select ? iterm_mul.value : div_val;
        end
      end
      ST_G_TAKE: begin
        if (form_select) begin
          total <= TOTAL_W'(bias) + TOTAL_W'(mul_q) + TOTAL_W'(iterm) - TOTAL_W'(dterm);
        end else begin
          total <= TOTAL_W'(bias) + TOTAL_W'(mul_q);
        end
      end
      default: ;
    endcase
  end

  // Integral, previous integral and last measurement
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc     <= '0;
      integral_prev    <= '0;
      last_measurement <= '0;
    end else if (state == ST_IDLE && s_tvalid) begin
      case (mode)
        MODE_LOAD:    integral_acc <= integral_load;
        MODE_RESTORE: integral_acc <= integral_prev;
        default: ;
      endcase
    end else if (state == ST_I_CLAMP) begin
      integral_acc     <= acc_clamped;
      integral_prev    <= integral_acc;
      last_measurement <= meas;
    end
  end

  // Output register: load the next result when free, else drop a taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      m_tdata <= {integral_acc, drive_sat.value};
      m_tuser <= drive_sat.clip;
    end
  end

endmodule
